[hw/rtl/astt_pkg.sv]
// ----------------------------------------------------------------------------
// astt_pkg
// Types and constants of the address and size tracking table.
// ----------------------------------------------------------------------------
package astt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = 64;
  localparam int SIZE_W   = 64;
  localparam int ENTRY_W  = 7;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

[hw/rtl/address_size_tracking_table_core.sv]
// ----------------------------------------------------------------------------
// address_size_tracking_table_core
// Ordered table of address and size pairs with add, delete, find and clear.
// ----------------------------------------------------------------------------
// steps: clear goes straight to the result register; add, find and delete
//   compare one entry at a time (memory with one write and one read port,
//   registered read) until a hit or the last entry, pass through S_MISS on a
//   miss, and delete then shifts each later entry down by one.
// throughput: one transaction at a time; in_ready is high only when idle.
// reset: synchronous active-low rst_n empties the table and drops out_valid;
//   the entry memory is not cleared.
module address_size_tracking_table_core
  import astt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [ADDR_W-1:0]  in_block_addr,
  input  logic [SIZE_W-1:0]  in_block_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [SIZE_W-1:0]  out_found_size,
  output logic [ENTRY_W-1:0] out_entry_count
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  state_t state_r, state_nxt;

  logic [1:0]         op_r, op_nxt;
  logic [ADDR_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [SIZE_W-1:0]  res_found_r, res_found_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [SIZE_W-1:0]  out_found_r, out_found_nxt;
  logic [ENTRY_W-1:0] out_count_r, out_count_nxt;

  logic               in_accept;
  logic               out_load;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W-1:0]   idx_p2;
  logic               key_hit;
  logic               is_full;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign idx_p1  = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_p2  = CNT_W'(idx_r) + CNT_W'(2);
  assign key_hit = (rd_data_r.key == key_r);
  assign is_full = (count_r == CNT_W'(CAPACITY));

  // entry memory with one write and one read port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_func == OP_CLEAR) begin
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (key_hit) begin
          if (op_r == OP_DEL && idx_p1 != count_r) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (idx_p1 == count_r) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_MISS:     state_nxt = S_DONE;
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (idx_p2 == count_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{key: key_r, size: size_r};
    rd_addr        = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt         = in_func;
          key_nxt        = in_block_addr;
          size_nxt       = in_block_size;
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          if (in_func == OP_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      S_CMP: begin
        if (key_hit) begin
          case (op_r)
            OP_ADD: begin
              // update in place, order kept
              wr_en = 1'b1;
            end
            OP_FIND: res_found_nxt = rd_data_r.size;
            OP_DEL: begin
              if (idx_p1 == count_r) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end else if (idx_p1 != count_r) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_MISS: begin
        if (op_r == OP_ADD) begin
          if (is_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end else begin
          res_status_nxt = ST_MISSING;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = idx_p1[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_p2 == count_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = ENTRY_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    size_r       <= size_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_size  = out_found_r;
  assign out_entry_count = out_count_r;

  // table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // clear empties the table in the next cycle
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_func == OP_CLEAR |=> count_r == '0)
    else $error("clear did not empty the table");

  // full is only reported when the table is at capacity
  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_status_r == ST_FULL |-> is_full)
    else $error("full status with room left");

  // a failed lookup never returns a size
  a_missing_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_status_r != ST_OK |-> res_found_r == '0)
    else $error("size returned on failed request");

endmodule
